FILE: rtl/minifloat_add_sub_mul_unit_macros.svh
// ----------------------------------------------------------------------------
// minifloat unit assertion macros
// shared concurrent assertion helpers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef MINIFLOAT_ADD_SUB_MUL_UNIT_MACROS_SVH
`define MINIFLOAT_ADD_SUB_MUL_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define MF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define MF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/mfasm_pkg.sv
// ----------------------------------------------------------------------------
// mfasm_pkg
// shared types and constants of the minifloat unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package mfasm_pkg;
  localparam logic [12:0] QNAN = 13'h0F10;
  localparam logic [3:0] EXP_TOP = 4'd15;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_BAD = 2'd3
  } op_t;

  // result class decided in the front part
  typedef enum logic [1:0] {
    CL_FIXED = 2'd0,
    CL_ADD   = 2'd1,
    CL_MUL   = 2'd2
  } cls_t;

  typedef struct packed {
    cls_t        cls;
    logic        bad;
    logic [12:0] fixed;
    logic        sa;
    logic        sb;
    logic [3:0]  ea;
    logic [3:0]  eb;
    logic [8:0]  ma;
    logic [8:0]  mb;
  } job_t;
endpackage

FILE: rtl/minifloat_add_sub_mul_unit.sv
// ----------------------------------------------------------------------------
// minifloat_add_sub_mul_unit
// 13-bit minifloat add, subtract and multiply with round to nearest even
// ----------------------------------------------------------------------------
// usage: send one word per operation on the in_ channel; tuser carries the
//   operation (0 add, 1 subtract, 2 multiply, 3 invalid), tdata the operands
// each word yields exactly one result word on the out_ channel, in order;
//   tdata holds the rounded value, tuser flags an invalid operation code
// datapath: the front register loads at acceptance, then the queue, the
//   align/multiply stage and the normalize/round stage are registered in turn
// throughput: one word per cycle while out_tready is high; the path is set by
//   the 9x9 multiply in the first back stage and the normalize/round stage after it
// stall: when out_tready is low the back stages hold, the two-entry queue
//   fills, and then in_tready drops; nothing is lost or repeated
// reset: synchronous active-low rst_n empties all stages and the queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "minifloat_add_sub_mul_unit_macros.svh"
module minifloat_add_sub_mul_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // operand_a[12:0], operand_b[25:13], zeros
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // result_value[12:0], zeros
  output logic        out_tuser   // bad_operation
);
  logic            f_vld, f_rdy, q_vld, q_rdy;
  mfasm_pkg::job_t f_job, q_job;
  logic [12:0]     res;

  mfasm_front u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_kind(in_tuser), .in_a(in_tdata[12:0]), .in_b(in_tdata[25:13]),
    .job_valid(f_vld), .job_ready(f_rdy), .job(f_job)
  );

  // queue decouples classification from arithmetic
  mfasm_queue u_queue (
    .clk, .rst_n,
    .wr_valid(f_vld), .wr_ready(f_rdy), .wr_job(f_job),
    .rd_valid(q_vld), .rd_ready(q_rdy), .rd_job(q_job)
  );

  mfasm_back u_back (
    .clk, .rst_n,
    .job_valid(q_vld), .job_ready(q_rdy), .job(q_job),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_value(res), .out_bad(out_tuser)
  );

  assign out_tdata = {3'd0, res};

  // invalid operations always return zero
  `MF_ASSERT_IMPL(a_bad_zero, clk, rst_n, out_tvalid && out_tuser, res == 13'd0)
  // a stalled result holds
  `MF_ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready,
                  out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  // queue full means front cannot be drained
  `MF_ASSERT_IMPL(a_flow, clk, rst_n, !f_rdy, q_vld)
endmodule

FILE: rtl/mfasm_front.sv
// ----------------------------------------------------------------------------
// mfasm_front
// decodes operation and classifies special operands into a job word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mfasm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_kind,
  input  logic [12:0]       in_a,
  input  logic [12:0]       in_b,
  output logic              job_valid,
  input  logic              job_ready,
  output mfasm_pkg::job_t   job
);
  mfasm_pkg::job_t job_r, job_nxt;
  logic vld_r;
  logic [12:0] b;
  logic sa, sb, na, nb, ia, ib, za, zb;

  assign in_ready  = !vld_r || job_ready;
  assign job_valid = vld_r;
  assign job       = job_r;

  always_comb begin
    b  = (in_kind == mfasm_pkg::OP_SUB) ? (in_b ^ 13'h1000) : in_b;
    sa = in_a[12];
    sb = b[12];
    na = (in_a[11:8] == mfasm_pkg::EXP_TOP) && (in_a[7:0] != 8'd0);
    nb = (b[11:8] == mfasm_pkg::EXP_TOP) && (b[7:0] != 8'd0);
    ia = (in_a[11:8] == mfasm_pkg::EXP_TOP) && (in_a[7:0] == 8'd0);
    ib = (b[11:8] == mfasm_pkg::EXP_TOP) && (b[7:0] == 8'd0);
    za = in_a[11:8] == 4'd0;
    zb = b[11:8] == 4'd0;
    job_nxt.bad   = 1'b0;
    job_nxt.cls   = mfasm_pkg::CL_FIXED;
    job_nxt.fixed = 13'd0;
    job_nxt.sa    = sa;
    job_nxt.sb    = sb;
    job_nxt.ea    = in_a[11:8];
    job_nxt.eb    = b[11:8];
    job_nxt.ma    = {1'b1, in_a[7:0]};
    job_nxt.mb    = {1'b1, b[7:0]};
    unique case (in_kind)
      mfasm_pkg::OP_ADD, mfasm_pkg::OP_SUB: begin
        if (na || nb) job_nxt.fixed = mfasm_pkg::QNAN;
        else if (ia && ib) job_nxt.fixed = (sa == sb) ? in_a : mfasm_pkg::QNAN;
        else if (ia) job_nxt.fixed = in_a;
        else if (ib) job_nxt.fixed = b;
        else if (za && zb) job_nxt.fixed = {sa & sb, 12'd0};
        else if (zb) job_nxt.fixed = in_a;
        else if (za) job_nxt.fixed = b;
        else job_nxt.cls = mfasm_pkg::CL_ADD;
      end
      mfasm_pkg::OP_MUL: begin
        if (na || nb) job_nxt.fixed = mfasm_pkg::QNAN;
        else if (ia || ib)
          job_nxt.fixed = (za || zb) ? mfasm_pkg::QNAN : {sa ^ sb, 4'hF, 8'd0};
        else if (za || zb) job_nxt.fixed = {sa ^ sb, 12'd0};
        else job_nxt.cls = mfasm_pkg::CL_MUL;
      end
      default: job_nxt.bad = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      job_r <= job_nxt;
    end
  end
endmodule

FILE: rtl/mfasm_queue.sv
// ----------------------------------------------------------------------------
// mfasm_queue
// two-entry queue of jobs between front and back parts
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mfasm_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  mfasm_pkg::job_t  wr_job,
  output logic             rd_valid,
  input  logic             rd_ready,
  output mfasm_pkg::job_t  rd_job
);
  mfasm_pkg::job_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr_en, rd_en;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_job   = mem_r[rp_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= !wp_r;
      if (rd_en) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_job;
  end
endmodule

FILE: rtl/mfasm_back.sv
// ----------------------------------------------------------------------------
// mfasm_back
// two-stage datapath: align/add or multiply, then normalize, round and pack
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mfasm_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_valid,
  output logic             job_ready,
  input  mfasm_pkg::job_t  job,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [12:0]      out_value,
  output logic             out_bad
);
  // stage 1 registers
  logic        s1_vld_r;
  logic        s1_fix_r;
  logic [12:0] s1_fixed_r;
  logic        s1_bad_r;
  logic        s1_s_r;
  logic [23:0] s1_m_r;
  logic signed [6:0] s1_base_r;
  // stage 2 registers
  logic        s2_vld_r;
  logic [12:0] s2_val_r;
  logic        s2_bad_r;

  logic s1_adv, s2_adv;
  logic sw, sb1, sa1, s1_s;
  logic [3:0] eh, el, d;
  logic [8:0] mh, ml;
  logic [23:0] big, m1;
  logic signed [6:0] base1;
  logic fix1;
  logic [12:0] fixed1;

  assign s2_adv    = !s2_vld_r || out_ready;
  assign s1_adv    = !s1_vld_r || s2_adv;
  assign job_ready = s1_adv;
  assign out_valid = s2_vld_r;
  assign out_value = s2_val_r;
  assign out_bad   = s2_bad_r;

  always_comb begin
    sw  = job.ea < job.eb;
    eh  = sw ? job.eb : job.ea;
    el  = sw ? job.ea : job.eb;
    mh  = sw ? job.mb : job.ma;
    ml  = sw ? job.ma : job.mb;
    sa1 = sw ? job.sb : job.sa;
    sb1 = sw ? job.sa : job.sb;
    d   = eh - el;
    big = {15'd0, mh} << d;
    fix1   = job.cls == mfasm_pkg::CL_FIXED;
    fixed1 = job.fixed;
    s1_s   = sa1;
    m1     = 24'd0;
    base1  = $signed({3'd0, el}) - 7'sd8;
    if (job.cls == mfasm_pkg::CL_MUL) begin
      m1    = {6'd0, {9'd0, job.ma} * {9'd0, job.mb}};
      s1_s  = job.sa ^ job.sb;
      base1 = $signed({3'd0, job.ea}) + $signed({3'd0, job.eb}) - 7'sd23;
    end else if (sa1 == sb1) begin
      m1 = big + {15'd0, ml};
    end else if (big > {15'd0, ml}) begin
      m1 = big - {15'd0, ml};
    end else if (big < {15'd0, ml}) begin
      m1   = {15'd0, ml} - big;
      s1_s = sb1;
    end else if (job.cls == mfasm_pkg::CL_ADD) begin
      fix1   = 1'b1;
      fixed1 = 13'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (s1_adv) s1_vld_r <= job_valid;
      if (s2_adv) s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && job_valid) begin
      s1_fix_r   <= fix1;
      s1_fixed_r <= fixed1;
      s1_bad_r   <= job.bad;
      s1_s_r     <= s1_s;
      s1_m_r     <= m1;
      s1_base_r  <= base1;
    end
  end

  // stage 2: normalize, round, pack
  logic [4:0] p;
  logic [4:0] sh;
  logic [23:0] q, rem, half, mask;
  logic [9:0] qr;
  logic signed [7:0] e;
  logic up;
  logic [12:0] val2;

  always_comb begin
    p = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (s1_m_r[i]) p = 5'(i);
    end
    e    = 8'(s1_base_r) + $signed({3'd0, p});
    sh   = 5'd0;
    qr   = 10'd0;
    q    = 24'd0;
    rem  = 24'd0;
    half = 24'd0;
    mask = 24'd0;
    up   = 1'b0;
    if (p > 5'd8) begin
      sh   = p - 5'd8;
      mask = (24'd1 << sh) - 24'd1;
      rem  = s1_m_r & mask;
      half = 24'd1 << (sh - 5'd1);
      q    = s1_m_r >> sh;
      up   = (rem > half) || ((rem == half) && q[0]);
      qr   = {1'b0, q[8:0]} + {9'd0, up};
      if (qr[9]) begin
        qr = qr >> 1;
        e  = e + 8'sd1;
      end
    end else begin
      qr = {1'b0, s1_m_r[8:0] << (5'd8 - p)};
    end
    if (s1_fix_r) val2 = s1_fixed_r;
    else if (e >= 8'sd15) val2 = {s1_s_r, 4'hF, 8'd0};
    else if (e <= 8'sd0) val2 = {s1_s_r, 12'd0};
    else val2 = {s1_s_r, e[3:0], qr[7:0]};
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_vld_r) begin
      s2_val_r <= val2;
      s2_bad_r <= s1_bad_r;
    end
  end
endmodule

FILE: tb/minifloat_add_sub_mul_unit_tb.sv
// ----------------------------------------------------------------------------
// minifloat_add_sub_mul_unit_tb
// self-checking bench: directed special cases, then random operations under
// three back-pressure patterns, each result checked against a local predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module minifloat_add_sub_mul_unit_tb;
  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // operand_a[12:0], operand_b[25:13], zeros
  logic [1:0]  in_tuser;   // kind[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // result_value[12:0], zeros
  logic        out_tuser;  // bad_operation

  typedef struct {
    logic [12:0] value;
    logic        bad;
  } mf_result_t;

  mf_result_t pending_results[$];
  int         error_count = 0;
  int         words_sent = 0;
  int         words_checked = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;

  minifloat_add_sub_mul_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // round magnitude m (top bit at p gives exponent base + p) to 9 bits
  function automatic logic [12:0] mf_round_pack(logic s, logic [31:0] m, int base);
    int          p;
    int          e;
    logic [31:0] q;
    logic [31:0] rem;
    logic [31:0] half;
    p = 0;
    while (p < 31 && (m >> p) > 1) p++;
    e = base + p;
    if (p > 8) begin
      rem  = m & ((32'd1 << (p - 8)) - 1);
      half = 32'd1 << (p - 9);
      q    = m >> (p - 8);
      if (rem > half || (rem == half && q[0])) q++;
      // rounding carry out of the significand
      if (q >= 32'h200) begin
        q = q >> 1;
        e++;
      end
    end else begin
      q = m << (8 - p);
    end
    if (e >= 15) return {s, 4'hF, 8'h00};
    if (e <= 0) return {s, 12'h000};
    return {s, e[3:0], q[7:0]};
  endfunction

  function automatic logic mf_is_nan(logic [12:0] v);
    return v[11:8] == 4'hF && v[7:0] != 0;
  endfunction

  function automatic logic mf_is_inf(logic [12:0] v);
    return v[11:8] == 4'hF && v[7:0] == 0;
  endfunction

  function automatic logic [12:0] mf_sum(logic [12:0] a, logic [12:0] b);
    logic        sa, sb, s;
    logic [3:0]  ea, eb;
    logic [31:0] ma, mb, big, m;
    if (mf_is_nan(a) || mf_is_nan(b)) return mfasm_pkg::QNAN;
    if (mf_is_inf(a) && mf_is_inf(b)) return (a[12] == b[12]) ? a : mfasm_pkg::QNAN;
    if (mf_is_inf(a)) return a;
    if (mf_is_inf(b)) return b;
    if (a[11:8] == 0 && b[11:8] == 0) return {a[12] & b[12], 12'h000};
    if (b[11:8] == 0) return a;
    if (a[11:8] == 0) return b;
    sa = a[12]; ea = a[11:8]; ma = {24'd1, a[7:0]};
    sb = b[12]; eb = b[11:8]; mb = {24'd1, b[7:0]};
    if (ea < eb) begin
      {sa, sb} = {sb, sa};
      {ea, eb} = {eb, ea};
      {ma, mb} = {mb, ma};
    end
    big = ma << (ea - eb);
    if (sa == sb) begin
      m = big + mb; s = sa;
    end else if (big > mb) begin
      m = big - mb; s = sa;
    end else if (big < mb) begin
      m = mb - big; s = sb;
    end else begin
      return 13'h0000;  // exact cancellation is +0
    end
    return mf_round_pack(s, m, int'(eb) - 8);
  endfunction

  function automatic logic [12:0] mf_product(logic [12:0] a, logic [12:0] b);
    logic s;
    s = a[12] ^ b[12];
    if (mf_is_nan(a) || mf_is_nan(b)) return mfasm_pkg::QNAN;
    if (mf_is_inf(a) || mf_is_inf(b)) begin
      if (a[11:8] == 0 || b[11:8] == 0) return mfasm_pkg::QNAN;
      return {s, 4'hF, 8'h00};
    end
    if (a[11:8] == 0 || b[11:8] == 0) return {s, 12'h000};
    return mf_round_pack(s, {24'd1, a[7:0]} * {24'd1, b[7:0]},
                         int'(a[11:8]) + int'(b[11:8]) - 23);
  endfunction

  function automatic mf_result_t mf_predict(mfasm_pkg::op_t op, logic [12:0] a,
                                            logic [12:0] b);
    mf_result_t r;
    r.value = 13'h0000;
    r.bad   = 1'b0;
    case (op)
      mfasm_pkg::OP_ADD: r.value = mf_sum(a, b);
      mfasm_pkg::OP_SUB: r.value = mf_sum(a, b ^ 13'h1000);
      mfasm_pkg::OP_MUL: r.value = mf_product(a, b);
      default: r.bad = 1'b1;
    endcase
    return r;
  endfunction

  // drive one word at the falling edge, hold until the handshake completes
  task automatic send_word(mfasm_pkg::op_t op, logic [12:0] a, logic [12:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'd0, b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(mf_predict(op, a, b));
    words_sent++;
    @(negedge clk);
  endtask

  // receiver: random stall, checks each accepted word against the oldest prediction
  always @(negedge clk) begin
    if (rst_n) out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word value=%h bad=%b", out_tdata[12:0], out_tuser);
        error_count++;
      end else begin
        mf_result_t exp_r;
        exp_r = pending_results.pop_front();
        words_checked++;
        if (out_tdata[12:0] !== exp_r.value) begin
          $error("result_value expected %h actual %h", exp_r.value, out_tdata[12:0]);
          error_count++;
        end
        if (out_tdata[15:13] !== 3'b000) begin
          $error("tdata padding expected 0 actual %b", out_tdata[15:13]);
          error_count++;
        end
        if (out_tuser !== exp_r.bad) begin
          $error("bad_operation expected %b actual %b", exp_r.bad, out_tuser);
          error_count++;
        end
      end
    end
  end

  // operand with a biased choice of class so special cases show up often
  function automatic logic [12:0] rand_operand();
    logic [12:0] v;
    v = 13'($urandom);
    case ($urandom_range(9))
      0: v[11:8] = 4'h0;                           // zero (fraction ignored)
      1: v[11:0] = {4'hF, 8'h00};                  // infinity
      2: v[11:8] = 4'hF;                           // mostly NaN
      3: v[11:8] = 4'($urandom_range(1, 2));       // near underflow
      4: v[11:8] = 4'($urandom_range(13, 14));     // near overflow
      default: ;
    endcase
    return v;
  endfunction

  task automatic test_directed_specials();
    mfasm_pkg::op_t op;
    for (int k = 0; k < 4; k++) begin
      op = mfasm_pkg::op_t'(k);
      send_word(op, 13'h0700, 13'h0700);  // one with one
      send_word(op, 13'h0F00, 13'h1F00);  // inf with -inf
      send_word(op, 13'h0F01, 13'h0700);  // NaN operand
      send_word(op, 13'h0F00, 13'h00FF);  // inf with zero
      send_word(op, 13'h1000, 13'h1000);  // -0 with -0
    end
    send_word(mfasm_pkg::OP_ADD, 13'h0E7F, 13'h0E7F);  // overflow
    send_word(mfasm_pkg::OP_MUL, 13'h0100, 13'h0100);  // underflow to zero
    send_word(mfasm_pkg::OP_ADD, 13'h0701, 13'h0180);  // exact sum, no rounding needed
    send_word(mfasm_pkg::OP_ADD, 13'h07FF, 13'h0580);  // tie rounds up to even
    send_word(mfasm_pkg::OP_SUB, 13'h1ABC, 13'h1ABC);  // exact cancellation to +0
    send_word(mfasm_pkg::OP_MUL, 13'h1FFF, 13'h1FFF);  // all ones
  endtask

  task automatic test_random_ops(int count);
    for (int i = 0; i < count; i++)
      send_word(mfasm_pkg::op_t'($urandom_range(3)), rand_operand(), rand_operand());
  endtask

  initial begin
    int drain;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = mfasm_pkg::OP_ADD;
    out_tready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 11; recv_idle_pct = 76;
    test_directed_specials();
    test_random_ops(300);
    send_idle_pct = 76; recv_idle_pct = 11;
    test_random_ops(300);
    send_idle_pct = 0;  recv_idle_pct = 0;
    test_random_ops(300);
    in_tvalid <= 1'b0;

    drain = 0;
    while (pending_results.size() != 0 && drain < 100000) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d result words never arrived", pending_results.size());
      error_count++;
    end
    $display("sent %0d words (add, sub, mul, invalid; specials and random)", words_sent);
    $display("checked %0d results across three stall patterns", words_checked);
    if (error_count == 0) begin
      $display("minifloat_add_sub_mul_unit: match");
    end else begin
      $display("minifloat_add_sub_mul_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("minifloat_add_sub_mul_unit: mismatch");
    $finish;
  end
endmodule
